// File: rtl/tabw_pkg.sv
// Shared constants and elaboration-time curve table builders for the waveshaper.
package tabw_pkg;

   // Register file layout
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TANH_DRIVE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARCTAN_DRIVE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_FACTOR   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_GAIN  = 2'd3;

   // Field widths of the control registers
   localparam int DRIVE_W  = 12;
   localparam int WEIGHT_W = 16;

   localparam logic [DRIVE_W-1:0]  DRIVE_RESET = 12'd256;
   localparam logic [WEIGHT_W-1:0] MIX_RESET   = 16'd16384;
   localparam logic [WEIGHT_W-1:0] GAIN_RESET  = 16'd16384;
   localparam logic [WEIGHT_W-1:0] MIX_ONE     = 16'd32768;

   // Interpolation fraction and final rounding position
   localparam int FRAC_W      = 16;
   localparam int ROUND_SHIFT = 29;

   // Curve lanes
   localparam int LANE_TANH = 0;
   localparam int LANE_ATAN = 1;
   localparam int LANES     = 2;

   localparam longint unsigned Q30_ONE   = 64'd1 << 30;
   localparam longint unsigned Q30_THIRD = Q30_ONE / 3;

   // unsigned quotient by shift and subtract, used only while building the tables
   function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
      logic [64:0]     rem;
      longint unsigned quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^(-f) in Q30 for 0 <= f <= 1.0 (Q30), Taylor series
   function automatic longint unsigned exp_neg_frac(longint unsigned f);
      longint          sum;
      longint unsigned term;
      sum  = longint'(Q30_ONE);
      term = Q30_ONE;
      for (int n = 1; n <= 24; n++) begin
         term = div_u64((term * f) >> 30, 64'(n));
         if (n[0]) sum = sum - longint'(term);
         else      sum = sum + longint'(term);
      end
      return (sum < 0) ? 64'd0 : longint'(unsigned'(sum));
   endfunction

   // atan(a) in Q30 for 0 <= a <= 0.5 (Q30)
   function automatic longint atan_small(longint unsigned a);
      longint          sum;
      longint unsigned a2;
      longint unsigned p;
      longint unsigned term;
      sum = longint'(a);
      a2  = (a * a) >> 30;
      p   = a;
      for (int n = 1; n <= 30; n++) begin
         p    = (p * a2) >> 30;
         term = div_u64(p, 64'(2 * n + 1));
         if (n[0]) sum = sum - longint'(term);
         else      sum = sum + longint'(term);
      end
      return sum;
   endfunction

   // Q30 to sample magnitude, round half up, clamp to full scale minus one
   function automatic longint unsigned q30_to_sample(longint v, int sb);
      int              sh;
      longint          vc;
      longint unsigned r;
      longint unsigned top;
      sh  = 31 - sb;
      vc  = (v < 0) ? 64'sd0 : v;
      r   = (longint'(unsigned'(vc)) + (64'd1 << (sh - 1))) >> sh;
      top = (64'd1 << (sb - 1)) - 64'd1;
      return (r > top) ? top : r;
   endfunction

   // tanh(16k/N) as a sample magnitude
   function automatic longint unsigned tanh_point(longint unsigned k, longint unsigned n_ent,
                                                  int sb);
      longint unsigned e1;
      longint unsigned u;
      longint unsigned ip;
      longint unsigned e;
      longint unsigned th;
      e1 = exp_neg_frac(Q30_ONE);
      u  = div_u64((64'd32 * k) << 30, n_ent);
      ip = u >> 30;
      e  = exp_neg_frac(u & (Q30_ONE - 64'd1));
      for (longint unsigned j = 0; j < ip; j++) begin
         e = (e * e1) >> 30;
      end
      th = div_u64((Q30_ONE - e) << 30, Q30_ONE + e);
      return q30_to_sample(longint'(th), sb);
   endfunction

   // (2/pi) atan(16k/N) as a sample magnitude
   function automatic longint unsigned atan_point(longint unsigned k, longint unsigned n_ent,
                                                  int sb);
      longint          atan_half;
      longint          pi_half;
      bit              flip;
      longint unsigned s;
      longint unsigned d;
      longint unsigned q;
      longint          r;
      atan_half = atan_small(Q30_ONE >> 1);
      pi_half   = 2 * (atan_half + atan_small(Q30_THIRD));
      flip      = (64'd16 * k) > n_ent;
      if (flip) s = div_u64(n_ent << 30, 64'd16 * k);
      else      s = div_u64((64'd16 * k) << 30, n_ent);
      if (s <= (Q30_ONE >> 1)) begin
         r = atan_small(s);
      end else begin
         d = s - (Q30_ONE >> 1);
         q = div_u64(d << 30, Q30_ONE + (s >> 1));
         r = atan_half + atan_small(q);
      end
      if (flip) r = pi_half - r;
      if (r < 0) r = 0;
      return q30_to_sample(
         longint'(div_u64(unsigned'(r) << 30, unsigned'(pi_half))), sb);
   endfunction

endpackage

// File: rtl/tanh_arctan_blend_waveshaper.sv
// Top level: tanh / arctan soft-clip waveshaper with crossfade, gain and saturation.
// A word accepted on req_ passes through 7 register stages before it is offered on rsp_.
// Throughput: one word per clock; a stall on rsp_ freezes every stage together.
// The depth is set by the drive multiply, table position multiply, table read,
// interpolation multiply, blend multiplies, gain multiply and rounding stages.
// Reset (synchronous, active high) empties the pipeline and restores register defaults.
module tanh_arctan_blend_waveshaper #(
   parameter int CURVE_TABLE_ENTRIES = 256,
   parameter int SAMPLE_BITS         = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input words
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   // result words
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                                   rsp_clipped,
   // register writes
   input  logic                                   csr_write_en,
   input  logic [tabw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tabw_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int STAGES      = 7;
   localparam int ENT_W       = SAMPLE_BITS - 1;
   localparam int ARG_W       = SAMPLE_BITS + tabw_pkg::DRIVE_W;
   localparam int IDX_W       = $clog2(CURVE_TABLE_ENTRIES + 1);
   localparam int POS_W       = ARG_W + IDX_W;
   localparam int POS_SHIFT   = SAMPLE_BITS - 5;
   localparam int FRAC_W      = tabw_pkg::FRAC_W;
   localparam int BLEND_W     = tabw_pkg::WEIGHT_W + ENT_W;
   localparam int GPROD_W     = BLEND_W + tabw_pkg::WEIGHT_W;
   localparam int RND_W       = GPROD_W - tabw_pkg::ROUND_SHIFT;
   localparam int LANES       = tabw_pkg::LANES;

   localparam logic [IDX_W:0]         LAST_POS  = (IDX_W + 1)'(CURVE_TABLE_ENTRIES);
   localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(CURVE_TABLE_ENTRIES);
   localparam logic [GPROD_W-1:0]     RND_HALF  = GPROD_W'(1) << (tabw_pkg::ROUND_SHIFT - 1);
   localparam logic [RND_W-1:0]       FS_MAG    = RND_W'(1) << (SAMPLE_BITS - 1);
   localparam logic [RND_W-1:0]       POS_LIMIT = FS_MAG - RND_W'(1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

   // ---------------------------------------------------------------------------
   // Curve tables, fixed contents built at elaboration
   logic [ENT_W-1:0] tanh_rom [CURVE_TABLE_ENTRIES + 1];
   logic [ENT_W-1:0] atan_rom [CURVE_TABLE_ENTRIES + 1];

   for (genvar k = 0; k <= CURVE_TABLE_ENTRIES; k++) begin : g_rom
      localparam longint unsigned TANH_PT =
         tabw_pkg::tanh_point(64'(k), 64'(CURVE_TABLE_ENTRIES), SAMPLE_BITS);
      localparam longint unsigned ATAN_PT =
         tabw_pkg::atan_point(64'(k), 64'(CURVE_TABLE_ENTRIES), SAMPLE_BITS);
      assign tanh_rom[k] = TANH_PT[ENT_W-1:0];
      assign atan_rom[k] = ATAN_PT[ENT_W-1:0];
   end

   // ---------------------------------------------------------------------------
   // Control registers
   logic [tabw_pkg::DRIVE_W-1:0]  tanh_drive_ff;
   logic [tabw_pkg::DRIVE_W-1:0]  arctan_drive_ff;
   logic [tabw_pkg::WEIGHT_W-1:0] mix_factor_ff;
   logic [tabw_pkg::WEIGHT_W-1:0] output_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tanh_drive_ff   <= tabw_pkg::DRIVE_RESET;
         arctan_drive_ff <= tabw_pkg::DRIVE_RESET;
         mix_factor_ff   <= tabw_pkg::MIX_RESET;
         output_gain_ff  <= tabw_pkg::GAIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tabw_pkg::CSR_TANH_DRIVE:   tanh_drive_ff   <= csr_wdata[tabw_pkg::DRIVE_W-1:0];
            tabw_pkg::CSR_ARCTAN_DRIVE: arctan_drive_ff <= csr_wdata[tabw_pkg::DRIVE_W-1:0];
            tabw_pkg::CSR_MIX_FACTOR:   mix_factor_ff   <= csr_wdata;
            tabw_pkg::CSR_OUTPUT_GAIN:  output_gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline control: all stages move together when the output can take a word
   logic              advance;
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;

   assign advance   = !vld_ff[STAGES-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[STAGES-1];
   assign vld_in    = {vld_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: magnitude of the sample times each drive
   logic                   s1_neg_in, s1_neg_ff;
   logic [SAMPLE_BITS-1:0] s1_mag;
   logic [ARG_W-1:0]       s1_arg_in [LANES];
   logic [ARG_W-1:0]       s1_arg_ff [LANES];

   always_comb begin
      s1_neg_in = req_sample_in[SAMPLE_BITS-1];
      s1_mag    = s1_neg_in ? SAMPLE_BITS'(~unsigned'(req_sample_in) + 1'b1)
                            : unsigned'(req_sample_in);
      s1_arg_in[tabw_pkg::LANE_TANH] = ARG_W'(s1_mag) * ARG_W'(tanh_drive_ff);
      s1_arg_in[tabw_pkg::LANE_ATAN] = ARG_W'(s1_mag) * ARG_W'(arctan_drive_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_neg_ff <= s1_neg_in;
         s1_arg_ff <= s1_arg_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: table position, split into index and fraction, clamped at the end
   logic              s2_neg_ff;
   logic [POS_W-1:0]  s2_pos    [LANES];
   logic [IDX_W:0]    s2_idx    [LANES];
   logic [IDX_W-1:0]  s2_addr0_in [LANES];
   logic [IDX_W-1:0]  s2_addr1_in [LANES];
   logic [FRAC_W-1:0] s2_frac_in  [LANES];
   logic [IDX_W-1:0]  s2_addr0_ff [LANES];
   logic [IDX_W-1:0]  s2_addr1_ff [LANES];
   logic [FRAC_W-1:0] s2_frac_ff  [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s2_pos[l] = POS_W'(s1_arg_ff[l]) * POS_W'(CURVE_TABLE_ENTRIES);
         s2_idx[l] = s2_pos[l][POS_W-1 -: IDX_W + 1];
         if (s2_idx[l] >= LAST_POS) begin
            s2_addr0_in[l] = LAST_IDX;
            s2_addr1_in[l] = LAST_IDX;
            s2_frac_in[l]  = '0;
         end else begin
            s2_addr0_in[l] = s2_idx[l][IDX_W-1:0];
            s2_addr1_in[l] = s2_idx[l][IDX_W-1:0] + 1'b1;
            s2_frac_in[l]  = s2_pos[l][POS_SHIFT + FRAC_W - 1 -: FRAC_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_neg_ff   <= s1_neg_ff;
         s2_addr0_ff <= s2_addr0_in;
         s2_addr1_ff <= s2_addr1_in;
         s2_frac_ff  <= s2_frac_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: registered table reads of both neighbor points
   logic              s3_neg_ff;
   logic [ENT_W-1:0]  s3_y0_ff   [LANES];
   logic [ENT_W-1:0]  s3_y1_ff   [LANES];
   logic [FRAC_W-1:0] s3_frac_ff [LANES];

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_neg_ff                      <= s2_neg_ff;
         s3_frac_ff                     <= s2_frac_ff;
         s3_y0_ff[tabw_pkg::LANE_TANH]  <= tanh_rom[s2_addr0_ff[tabw_pkg::LANE_TANH]];
         s3_y1_ff[tabw_pkg::LANE_TANH]  <= tanh_rom[s2_addr1_ff[tabw_pkg::LANE_TANH]];
         s3_y0_ff[tabw_pkg::LANE_ATAN]  <= atan_rom[s2_addr0_ff[tabw_pkg::LANE_ATAN]];
         s3_y1_ff[tabw_pkg::LANE_ATAN]  <= atan_rom[s2_addr1_ff[tabw_pkg::LANE_ATAN]];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: linear interpolation on the magnitude, truncating the step
   logic                      s4_neg_ff;
   logic                      s4_up    [LANES];
   logic [ENT_W-1:0]          s4_diff  [LANES];
   logic [ENT_W+FRAC_W-1:0]   s4_scaled [LANES];
   logic [ENT_W-1:0]          s4_y_in  [LANES];
   logic [ENT_W-1:0]          s4_y_ff  [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s4_up[l]     = s3_y1_ff[l] > s3_y0_ff[l];
         s4_diff[l]   = s4_up[l] ? (s3_y1_ff[l] - s3_y0_ff[l]) : (s3_y0_ff[l] - s3_y1_ff[l]);
         s4_scaled[l] = (ENT_W + FRAC_W)'(s4_diff[l]) * (ENT_W + FRAC_W)'(s3_frac_ff[l]);
         s4_y_in[l]   = s4_up[l] ? (s3_y0_ff[l] + s4_scaled[l][ENT_W+FRAC_W-1:FRAC_W])
                                 : (s3_y0_ff[l] - s4_scaled[l][ENT_W+FRAC_W-1:FRAC_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_neg_ff <= s3_neg_ff;
         s4_y_ff   <= s4_y_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: crossfade; both curves share the sign of the sample, so blend magnitudes
   logic                          s5_neg_ff;
   logic [tabw_pkg::WEIGHT_W-1:0] s5_w_atan;
   logic [tabw_pkg::WEIGHT_W-1:0] s5_w_tanh;
   logic [BLEND_W-1:0]            s5_blend_in, s5_blend_ff;

   always_comb begin
      s5_w_atan   = (mix_factor_ff > tabw_pkg::MIX_ONE) ? tabw_pkg::MIX_ONE : mix_factor_ff;
      s5_w_tanh   = tabw_pkg::MIX_ONE - s5_w_atan;
      s5_blend_in = BLEND_W'(s5_w_tanh) * BLEND_W'(s4_y_ff[tabw_pkg::LANE_TANH])
                  + BLEND_W'(s5_w_atan) * BLEND_W'(s4_y_ff[tabw_pkg::LANE_ATAN]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_neg_ff   <= s4_neg_ff;
         s5_blend_ff <= s5_blend_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: master gain
   logic               s6_neg_ff;
   logic [GPROD_W-1:0] s6_prod_in, s6_prod_ff;

   assign s6_prod_in = GPROD_W'(s5_blend_ff) * GPROD_W'(output_gain_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_neg_ff  <= s5_neg_ff;
         s6_prod_ff <= s6_prod_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: round half away from zero, restore sign, saturate
   logic [GPROD_W-1:0]     s7_sum;
   logic [RND_W-1:0]       s7_rnd;
   logic [SAMPLE_BITS-1:0] out_sample_in, out_sample_ff;
   logic                   out_clip_in, out_clip_ff;

   always_comb begin
      s7_sum = s6_prod_ff + RND_HALF;
      s7_rnd = s7_sum[GPROD_W-1:tabw_pkg::ROUND_SHIFT];
      if (s6_neg_ff) begin
         out_clip_in   = s7_rnd > FS_MAG;
         out_sample_in = out_clip_in ? SAMPLE_MIN
                                     : SAMPLE_BITS'(~s7_rnd[SAMPLE_BITS-1:0] + 1'b1);
      end else begin
         out_clip_in   = s7_rnd > POS_LIMIT;
         out_sample_in = out_clip_in ? SAMPLE_MAX : s7_rnd[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= out_sample_in;
         out_clip_ff   <= out_clip_in;
      end
   end

   assign rsp_sample_out = signed'(out_sample_ff);
   assign rsp_clipped    = out_clip_ff;

endmodule

// File: rtl/tabw_checker.sv
// Port-level checker for the waveshaper, bound to the top level.
module tabw_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_clipped
);

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("result word present right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped))
      else $error("stalled result word changed");

   // a clipped word sits on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (unsigned'(rsp_sample_out) == SAMPLE_MAX) || (unsigned'(rsp_sample_out) == SAMPLE_MIN))
      else $error("clip flag set on a value that is not saturated");

   // backpressure on the output stops intake
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while the pipeline is stalled");

   // with the output empty the pipeline always takes a word
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with the output stage empty");

endmodule

bind tanh_arctan_blend_waveshaper tabw_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_tabw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_clipped    (rsp_clipped)
);

// File: tb/tb_tanh_arctan_blend_waveshaper.sv
// Testbench for the tanh/arctan blend waveshaper: streamed samples checked against a predictor.
`timescale 1ns / 1ps

module tb_tanh_arctan_blend_waveshaper;

   localparam int CURVE_POINTS = 256;
   localparam int SAMPLE_W = 16;
   localparam longint unsigned Q30_UNIT = 64'd1 << 30;
   localparam longint FULL_SCALE = 64'sd1 <<< (SAMPLE_W - 1);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_PHASES = 13;
   localparam int WORDS_PER_PHASE = 148;
   localparam logic [11:0] DRIVE_MAX = 12'hFFF;
   localparam logic [11:0] DRIVE_TOP = 12'd2560;
   localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic clipped;
   } shaped_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic rsp_clipped;
   logic csr_write_en = 1'b0;
   logic [tabw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tabw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // curve points and shadow copy of the register file
   bit [15:0] tanh_curve [0:CURVE_POINTS];
   bit [15:0] atan_curve [0:CURVE_POINTS];
   bit [11:0] tanh_drive_q = tabw_pkg::DRIVE_RESET;
   bit [11:0] atan_drive_q = tabw_pkg::DRIVE_RESET;
   bit [15:0] mix_q = tabw_pkg::MIX_RESET;
   bit [15:0] gain_q = tabw_pkg::GAIN_RESET;

   logic signed [SAMPLE_W-1:0] pending_samples [$];
   shaped_word_type shaped_due [$];
   logic in_taken = 1'b0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   // idle pattern state
   bit calm = 1'b0;
   int send_gap = 0;
   int recv_stall = 0;
   int stretch_left = 0;
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;

   tanh_arctan_blend_waveshaper #(
      .CURVE_TABLE_ENTRIES(CURVE_POINTS),
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .rsp_clipped(rsp_clipped),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // e^-f in Q30, Taylor series, 0 <= f <= 1
   function automatic bit [63:0] exp_neg_q30(bit [63:0] f);
      bit [63:0] term;
      longint acc;
      acc = longint'(Q30_UNIT);
      term = Q30_UNIT;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * f) >> 30) / 64'(n);
         if (n % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      return (acc < 0) ? 64'd0 : 64'(acc);
   endfunction

   // atan(a) in Q30, odd series, 0 <= a <= 0.5
   function automatic longint atan_q30(bit [63:0] a);
      bit [63:0] a2, p, term;
      longint acc;
      acc = longint'(a);
      a2 = (a * a) >> 30;
      p = a;
      for (int n = 1; n <= 30; n++) begin
         p = (p * a2) >> 30;
         term = p / 64'(2 * n + 1);
         if (n % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      return acc;
   endfunction

   // Q30 to sample magnitude, round half up, clamp below full scale
   function automatic bit [15:0] q30_to_mag(longint v);
      bit [63:0] r;
      if (v < 0) v = 0;
      r = (64'(v) + (64'd1 << (30 - SAMPLE_W))) >> (31 - SAMPLE_W);
      if (r > 64'(FULL_SCALE - 1)) r = 64'(FULL_SCALE - 1);
      return r[15:0];
   endfunction

   // curve points over arguments 0..16
   function automatic void build_curves();
      bit [63:0] e1, u, ip, e, th, s, d, q, ru, ph_u, sixteen_k;
      longint atan_half, pi_half, r;
      bit flip;
      e1 = exp_neg_q30(Q30_UNIT);
      atan_half = atan_q30(Q30_UNIT >> 1);
      pi_half = 2 * (atan_half + atan_q30(Q30_UNIT / 3));
      ph_u = pi_half;
      for (int k = 0; k <= CURVE_POINTS; k++) begin
         // tanh(t) = (1 - e^-2t) / (1 + e^-2t)
         u = ((64'd32 * 64'(k)) << 30) / 64'(CURVE_POINTS);
         ip = u >> 30;
         e = exp_neg_q30(u & (Q30_UNIT - 1));
         for (bit [63:0] j = 0; j < ip; j++) e = (e * e1) >> 30;
         th = ((Q30_UNIT - e) << 30) / (Q30_UNIT + e);
         tanh_curve[k] = q30_to_mag(longint'(th));
         // (2/pi) atan(t), reflected through 1/t above one
         sixteen_k = 64'd16 * 64'(k);
         flip = sixteen_k > 64'(CURVE_POINTS);
         if (flip) s = (64'(CURVE_POINTS) << 30) / sixteen_k;
         else s = (sixteen_k << 30) / 64'(CURVE_POINTS);
         if (s <= (Q30_UNIT >> 1)) begin
            r = atan_q30(s);
         end else begin
            d = s - (Q30_UNIT >> 1);
            q = (d << 30) / (Q30_UNIT + (s >> 1));
            r = atan_half + atan_q30(q);
         end
         if (flip) r = pi_half - r;
         if (r < 0) r = 0;
         ru = r;
         atan_curve[k] = q30_to_mag(longint'((ru << 30) / ph_u));
      end
   endfunction

   // interpolated curve magnitude for |x| and a Q4.8 drive
   function automatic longint curve_read(bit use_atan, longint mag, longint drive);
      bit [63:0] m, dr, pos, idx, frac, y0, y1, y;
      m = mag;
      dr = drive;
      pos = (m * dr * 64'(CURVE_POINTS)) >> (SAMPLE_W - 5);
      idx = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= 64'(CURVE_POINTS))
         return longint'(use_atan ? atan_curve[CURVE_POINTS] : tanh_curve[CURVE_POINTS]);
      y0 = 64'(use_atan ? atan_curve[idx] : tanh_curve[idx]);
      y1 = 64'(use_atan ? atan_curve[idx + 1] : tanh_curve[idx + 1]);
      y = y0;
      if (y1 > y0) y += ((y1 - y0) * frac) >> 16;
      else y -= ((y0 - y1) * frac) >> 16;
      return longint'(y);
   endfunction

   // full shaping path: both curves, crossfade, gain, round, saturate
   function automatic shaped_word_type shape_sample(logic signed [SAMPLE_W-1:0] x);
      shaped_word_type w;
      longint mag, th, at, mix, blend, prod, pm, rm;
      bit neg, pneg;
      neg = x[SAMPLE_W-1];
      mag = neg ? -longint'(x) : longint'(x);
      th = curve_read(1'b0, mag, longint'(tanh_drive_q));
      at = curve_read(1'b1, mag, longint'(atan_drive_q));
      if (neg) begin
         th = -th;
         at = -at;
      end
      mix = (mix_q > tabw_pkg::MIX_ONE) ? longint'(tabw_pkg::MIX_ONE) : longint'(mix_q);
      blend = (longint'(tabw_pkg::MIX_ONE) - mix) * th + mix * at;
      prod = blend * longint'(gain_q);
      pneg = prod < 0;
      pm = pneg ? -prod : prod;
      rm = (pm + (64'sd1 <<< 28)) >>> 29;
      w.clipped = 1'b0;
      if (pneg) begin
         if (rm > FULL_SCALE) begin
            rm = FULL_SCALE;
            w.clipped = 1'b1;
         end
         w.sample = SAMPLE_W'(-rm);
      end else begin
         if (rm > FULL_SCALE - 1) begin
            rm = FULL_SCALE - 1;
            w.clipped = 1'b1;
         end
         w.sample = SAMPLE_W'(rm);
      end
      return w;
   endfunction

   // random sample: corners, small magnitudes, or anything
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] low_mag;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'sh0001;
               default: return 16'shFFFF;
            endcase
         end
         1, 2: begin
            low_mag = SAMPLE_W'($urandom_range(0, 2047));
            return $urandom_range(0, 1) ? -low_mag : low_mag;
         end
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic write_csr(input logic [tabw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tabw_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         tabw_pkg::CSR_TANH_DRIVE: tanh_drive_q = value[11:0];
         tabw_pkg::CSR_ARCTAN_DRIVE: atan_drive_q = value[11:0];
         tabw_pkg::CSR_MIX_FACTOR: mix_q = value;
         tabw_pkg::CSR_OUTPUT_GAIN: gain_q = value;
      endcase
   endtask

   // all four registers; junk in the unused upper bits of the drives
   task automatic apply_settings(input logic [11:0] td, input logic [11:0] ad,
                                 input logic [15:0] mx, input logic [15:0] gn);
      write_csr(tabw_pkg::CSR_TANH_DRIVE, {4'($urandom()), td});
      write_csr(tabw_pkg::CSR_ARCTAN_DRIVE, {4'($urandom()), ad});
      write_csr(tabw_pkg::CSR_MIX_FACTOR, mx);
      write_csr(tabw_pkg::CSR_OUTPUT_GAIN, gn);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // block is idle: nothing queued, nothing offered, nothing outstanding
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || shaped_due.size() != 0);
   endtask

   // driver: sample words and result back-pressure, both with idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(40, 240);
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
         end else begin
            stretch_left--;
         end
         // sender: only moves on once the current word is gone
         if (!req_valid || in_taken) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_valid <= 1'b1;
               req_sample_in <= pending_samples.pop_front();
               if (!calm && !send_quiet && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
         // receiver
         if (recv_stall != 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (!calm && !recv_quiet && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predict on accepted samples, check accepted results, watchdog
   always @(posedge clock) begin
      shaped_word_type due;
      in_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (shaped_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual sample_out %0d clipped %0b",
                        $time, rsp_sample_out, rsp_clipped);
               mismatch_count++;
            end else begin
               due = shaped_due.pop_front();
               if (rsp_sample_out !== due.sample) begin
                  $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                           $time, $signed(due.sample), rsp_sample_out);
                  mismatch_count++;
               end
               if (rsp_clipped !== due.clipped) begin
                  $display("%0t: clipped mismatch, expected %0b, actual %0b",
                           $time, due.clipped, rsp_clipped);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) shaped_due = {shaped_due, shape_sample(req_sample_in)};
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tanh_arctan_blend_waveshaper test failed");
            $finish;
         end
      end
   end

   // stimulus: directed corners, then phases of random words under new settings
   initial begin
      logic [11:0] td, ad;
      logic [15:0] mx, gn;
      build_curves();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero, unit steps, full scale both ways, segment edges
      pending_samples = '{16'sh0000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000, 16'sh0100,
                          16'shFF00, 16'sh0008, 16'sh1000, -16'sd12345, 16'sh5555,
                          16'shAAAA};
      wait_drained();

      // maximum drives and gain: saturation in both directions
      apply_settings(DRIVE_MAX, DRIVE_MAX, tabw_pkg::MIX_RESET, WEIGHT_MAX);
      pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh0064, -16'sd100, 16'sh0001, 16'shFFFF,
                          16'sh0000, 16'sd20000};
      wait_drained();

      // tanh drive off, mix weight above one
      apply_settings(12'd0, DRIVE_TOP, 16'd40000, 16'd32768);
      pending_samples = '{16'sh7FFF, 16'sh8000, 16'sd5000};

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin td = tabw_pkg::DRIVE_RESET; ad = tabw_pkg::DRIVE_RESET;
               mx = 16'd0; gn = tabw_pkg::GAIN_RESET; end
            1: begin td = DRIVE_TOP; ad = DRIVE_TOP;
               mx = tabw_pkg::MIX_ONE; gn = 16'd32768; end
            2: begin td = 12'd0; ad = DRIVE_MAX; mx = tabw_pkg::MIX_RESET; gn = WEIGHT_MAX; end
            3: begin td = DRIVE_MAX; ad = 12'd0; mx = WEIGHT_MAX; gn = 16'd32768; end
            4: begin td = 12'd1000; ad = 12'd1500; mx = 16'd20000; gn = 16'd0; end
            default: begin
               td = ($urandom_range(0, 5) == 0) ? 12'($urandom()) : 12'($urandom_range(256, 2560));
               ad = ($urandom_range(0, 5) == 0) ? 12'($urandom()) : 12'($urandom_range(256, 2560));
               mx = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
               gn = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
            end
         endcase
         apply_settings(td, ad, mx, gn);
         // last phase runs flat out on both sides
         if (phase == RANDOM_PHASES - 1) calm = 1'b1;
         repeat (WORDS_PER_PHASE) pending_samples = {pending_samples, pick_sample()};
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tanh_arctan_blend_waveshaper test passed");
      end else begin
         $display("tanh_arctan_blend_waveshaper test failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tabw_pkg.sv
rtl/tanh_arctan_blend_waveshaper.sv
rtl/tabw_checker.sv
tb/tb_tanh_arctan_blend_waveshaper.sv
